>>> rtl/f64bc_pkg.sv
// ----------------------------------------------------------------------------
// f64bc_pkg
// shared constants, s-box table and key schedule for the 64-bit feistel cipher
// ----------------------------------------------------------------------------
package f64bc_pkg;

    localparam int NumRounds  = 32;
    localparam int NumKeys    = 8;
    localparam int HalfW      = 32;
    localparam int BlockW     = 64;
    localparam int RotAmount  = 11;
    localparam int EncSplit   = 25;
    localparam int DecSplit   = 9;
    localparam int KeyIdxW    = 3;
    localparam int RoundIdxW  = 5;
    localparam int AddrW      = 5;

    typedef logic [HalfW-1:0]   t_half;
    typedef logic [BlockW-1:0]  t_block;
    typedef logic [KeyIdxW-1:0] t_key_idx;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    localparam logic [3:0] SBOX [0:7][0:15] = '{
        '{4'd12, 4'd7,  4'd15, 4'd5,  4'd0,  4'd14, 4'd2,  4'd4,
          4'd10, 4'd13, 4'd9,  4'd3,  4'd8,  4'd1,  4'd6,  4'd11},
        '{4'd0,  4'd14, 4'd4,  4'd9,  4'd8,  4'd2,  4'd12, 4'd15,
          4'd6,  4'd1,  4'd7,  4'd11, 4'd10, 4'd13, 4'd5,  4'd3},
        '{4'd3,  4'd15, 4'd11, 4'd0,  4'd9,  4'd7,  4'd1,  4'd2,
          4'd5,  4'd13, 4'd4,  4'd12, 4'd14, 4'd10, 4'd6,  4'd8},
        '{4'd0,  4'd10, 4'd8,  4'd3,  4'd15, 4'd12, 4'd14, 4'd4,
          4'd11, 4'd9,  4'd6,  4'd2,  4'd7,  4'd13, 4'd1,  4'd5},
        '{4'd11, 4'd8,  4'd5,  4'd10, 4'd0,  4'd2,  4'd9,  4'd12,
          4'd3,  4'd7,  4'd14, 4'd13, 4'd6,  4'd1,  4'd4,  4'd15},
        '{4'd6,  4'd4,  4'd11, 4'd9,  4'd12, 4'd3,  4'd10, 4'd15,
          4'd8,  4'd7,  4'd5,  4'd14, 4'd2,  4'd1,  4'd0,  4'd13},
        '{4'd13, 4'd9,  4'd3,  4'd14, 4'd7,  4'd5,  4'd11, 4'd10,
          4'd8,  4'd1,  4'd0,  4'd15, 4'd6,  4'd4,  4'd2,  4'd12},
        '{4'd13, 4'd2,  4'd0,  4'd9,  4'd4,  4'd1,  4'd12, 4'd15,
          4'd8,  4'd11, 4'd10, 4'd3,  4'd14, 4'd6,  4'd5,  4'd7}
    };

    function automatic t_half substitute(input t_half x);
        t_half acc;
        acc = '0;
        for (int n = 0; n < 8; n++) begin
            acc[n*4 +: 4] = SBOX[n][x[n*4 +: 4]];
        end
        return acc;
    endfunction

    // zero-based round number, encrypt schedule is 0..7 x3 then 7..0,
    // decrypt is 0..7 then 7..0 x3
    function automatic t_key_idx key_sel(input logic [RoundIdxW-1:0] r0, input t_op op);
        logic [RoundIdxW-1:0] down;
        logic                 fwd;
        down = RoundIdxW'(NumRounds - 1) - r0;
        if (op == OP_DECRYPT) begin
            fwd = (r0 < RoundIdxW'(DecSplit - 1));
        end else begin
            fwd = (r0 < RoundIdxW'(EncSplit - 1));
        end
        return fwd ? r0[KeyIdxW-1:0] : down[KeyIdxW-1:0];
    endfunction

endpackage

>>> rtl/feistel64_block_cipher.sv
// ----------------------------------------------------------------------------
// feistel64_block_cipher
// 32-round feistel cipher, one round per pipeline stage, apb key registers
// throughput: one word per cycle while m_axis_tready is high, set by the 32-stage round pipeline
// stalls collapse bubbles stage by stage, nothing is dropped or repeated
// reset: synchronous active low, clears valid bits and key words to zero
// ----------------------------------------------------------------------------
module feistel64_block_cipher (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [63:0]               s_axis_tdata,   // [63:0] block_in
    input  logic                      s_axis_tuser,   // [0] op
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [63:0]               m_axis_tdata,   // [63:0] block_out
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [f64bc_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import f64bc_pkg::*;

    t_half    r_key [NumKeys];
    logic     r_v   [NumRounds];
    t_block   r_blk [NumRounds];
    t_op      r_op  [NumRounds];
    logic     w_ld  [NumRounds+1];
    t_key_idx w_widx;
    t_block   w_in;

    // key registers
    assign w_widx = paddr[AddrW-1:2];
    assign pready = 1'b1;
    assign prdata = r_key[w_widx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumKeys; k++) begin
                r_key[k] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            r_key[w_widx] <= pwdata;
        end
    end

    // decrypt runs the same round on swapped halves
    assign w_in = (s_axis_tuser == OP_DECRYPT)
                ? {s_axis_tdata[HalfW-1:0], s_axis_tdata[BlockW-1:HalfW]}
                : s_axis_tdata;

    assign w_ld[NumRounds] = m_axis_tready;
    assign s_axis_tready   = w_ld[0];

    for (genvar i = 0; i < NumRounds; i++) begin : g_stage
        t_block   w_src;
        t_op      w_sop;
        logic     w_sv;
        t_block   w_res;
        t_key_idx w_kidx;

        if (i == 0) begin : g_first
            assign w_src = w_in;
            assign w_sop = t_op'(s_axis_tuser);
            assign w_sv  = s_axis_tvalid;
        end else begin : g_rest
            assign w_src = r_blk[i-1];
            assign w_sop = r_op[i-1];
            assign w_sv  = r_v[i-1];
        end

        assign w_ld[i] = !r_v[i] || w_ld[i+1];
        assign w_kidx  = key_sel(RoundIdxW'(i), w_sop);

        f64bc_round u_round (
            .i_blk (w_src),
            .i_key (r_key[w_kidx]),
            .o_blk (w_res)
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (w_ld[i]) begin
                r_v[i] <= w_sv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ld[i] && w_sv) begin
                r_blk[i] <= w_res;
                r_op[i]  <= w_sop;
            end
        end
    end

    assign m_axis_tvalid = r_v[NumRounds-1];
    assign m_axis_tdata  = (r_op[NumRounds-1] == OP_DECRYPT)
                         ? {r_blk[NumRounds-1][HalfW-1:0], r_blk[NumRounds-1][BlockW-1:HalfW]}
                         : r_blk[NumRounds-1];

    a_empty_tail_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NumRounds-1] |-> s_axis_tready)
        else $error("input stalled with empty last stage");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v[0])
        else $error("accepted word missing in first stage");

    a_tail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NumRounds-1] && !m_axis_tready) |=> (r_v[NumRounds-1]
            && $stable(r_blk[NumRounds-1]) && $stable(r_op[NumRounds-1])))
        else $error("stalled result lost or changed");

endmodule

>>> rtl/f64bc_round.sv
// ----------------------------------------------------------------------------
// f64bc_round
// one feistel round: key add, s-box layer, rotate left, xor and half swap
// ----------------------------------------------------------------------------
module f64bc_round (
    input  f64bc_pkg::t_block i_blk,   // [31:0] right, [63:32] left
    input  f64bc_pkg::t_half  i_key,
    output f64bc_pkg::t_block o_blk    // [31:0] right, [63:32] left
);
    import f64bc_pkg::*;

    t_half w_left;
    t_half w_right;
    t_half w_sum;
    t_half w_sub;
    t_half w_rot;

    assign w_left  = i_blk[BlockW-1:HalfW];
    assign w_right = i_blk[HalfW-1:0];
    assign w_sum   = w_right + i_key;
    assign w_sub   = substitute(w_sum);
    assign w_rot   = {w_sub[HalfW-RotAmount-1:0], w_sub[HalfW-1:HalfW-RotAmount]};
    assign o_blk   = {w_right, w_left ^ w_rot};

endmodule
